// ===== rtl/tlvs_pkg.sv =====
`timescale 1ns / 1ps

package tlvs_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_WRONG_LEN = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET_TAG      = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Record header layout: tag bytes 0..1, length bytes 2..5
  localparam logic [2:0] HDR_TAG_LO  = 3'd0;
  localparam logic [2:0] HDR_TAG_HI  = 3'd1;
  localparam logic [2:0] HDR_LEN_B0  = 3'd2;
  localparam logic [2:0] HDR_LEN_B1  = 3'd3;
  localparam logic [2:0] HDR_LEN_B2  = 3'd4;
  localparam logic [2:0] HDR_LEN_B3  = 3'd5;

  localparam logic [3:0] WORD_BYTES  = 4'd8;

  // Output tdata layout
  localparam int unsigned OUT_DATA_W = 112;

endpackage

// ===== rtl/tlv_record_scanner.sv =====
`timescale 1ns / 1ps
// An item with tlast set shows its result on m_axis in the cycle after it is accepted.
// Throughput: one payload item per cycle; the only stall is a result held by m_axis_tready low.
// Each byte updates the header, length and value counters combinationally, between the
// parse state registers and the result register.
// Reset (rst_ni low, asynchronous): parse state cleared, target_tag and expected_length 0,
// no result pending.
module tlv_record_scanner import tlvs_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // payload in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  // result out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] value_offset, [47:16] value_length,
                                                // [111:48] value_word
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(BUFFER_BYTES);

  // configuration
  logic [15:0] target_tag_q;
  logic [3:0]  expected_len_q;

  // parse state
  logic [2:0]       hidx_q, hidx_d;
  logic [15:0]      tag_q, tag_d;
  logic [31:0]      len_q, len_d;
  logic [31:0]      left_q, left_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             match_q, match_d;
  logic [15:0]      start_q, start_d;
  logic [63:0]      word_q, word_d;
  logic [3:0]       vcnt_q, vcnt_d;   // value bytes collected, saturates at eight

  // result register
  logic        out_valid_q;
  logic [1:0]  out_status_q, res_status;
  logic [15:0] out_offset_q;
  logic [31:0] out_length_q;
  logic [63:0] out_word_q;

  logic         in_acc;
  logic [POS_W:0] pos_inc;
  logic         out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign pos_inc       = {1'b0, pos_q} + 1'b1;

  // Configuration: writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q   <= '0;
      expected_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TARGET_TAG:      target_tag_q   <= cfg_data_i;
        CFG_EXPECTED_LENGTH: expected_len_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Per-byte parse step.
  always_comb begin
    hidx_d  = hidx_q;
    tag_d   = tag_q;
    len_d   = len_q;
    left_d  = left_q;
    pos_d   = pos_q;
    match_d = match_q;
    start_d = start_q;
    word_d  = word_q;
    vcnt_d  = vcnt_q;

    if (match_q && left_q == '0) begin
      // match complete: ignore the rest of the buffer
    end else if (left_q != '0) begin
      // inside a value: collect if this is the matched record, else skip
      if (match_q && vcnt_q < WORD_BYTES) begin
        word_d[{vcnt_q[2:0], 3'b000} +: 8] = s_axis_tdata;
        vcnt_d = vcnt_q + 1'b1;
      end
      left_d = left_q - 1'b1;
    end else begin
      hidx_d = hidx_q + 1'b1;
      case (hidx_q)
        HDR_TAG_LO: begin
          tag_d = {8'h00, s_axis_tdata};
          len_d = '0;
        end
        HDR_TAG_HI: tag_d[15:8]  = s_axis_tdata;
        HDR_LEN_B0: len_d[7:0]   = s_axis_tdata;
        HDR_LEN_B1: len_d[15:8]  = s_axis_tdata;
        HDR_LEN_B2: len_d[23:16] = s_axis_tdata;
        HDR_LEN_B3: begin
          // header complete: arm the value skip and check the tag
          len_d[31:24] = s_axis_tdata;
          hidx_d       = HDR_TAG_LO;
          left_d       = {s_axis_tdata, len_q[23:0]};
          if (tag_q == target_tag_q) begin
            match_d = 1'b1;
            start_d = 16'(pos_inc);
            word_d  = '0;
            vcnt_d  = '0;
          end
        end
        default: hidx_d = HDR_TAG_LO;
      endcase
    end

    // byte count saturates at the buffer size
    if (pos_q < POS_MAX) begin
      pos_d = pos_inc[POS_W-1:0];
    end

    // verdict for a buffer ending on this byte
    if (left_d != '0) begin
      res_status = ST_MALFORMED;
    end else if (!match_d) begin
      res_status = ST_NOT_FOUND;
    end else if (expected_len_q != '0 && len_d != {28'd0, expected_len_q}) begin
      res_status = ST_WRONG_LEN;
    end else begin
      res_status = ST_FOUND;
    end
  end

  // Advance parse state on each accepted item; re-arm after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q  <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      match_q <= 1'b0;
      start_q <= '0;
      word_q  <= '0;
      vcnt_q  <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        hidx_q  <= '0;
        tag_q   <= '0;
        len_q   <= '0;
        left_q  <= '0;
        pos_q   <= '0;
        match_q <= 1'b0;
        start_q <= '0;
        word_q  <= '0;
        vcnt_q  <= '0;
      end else begin
        hidx_q  <= hidx_d;
        tag_q   <= tag_d;
        len_q   <= len_d;
        left_q  <= left_d;
        pos_q   <= pos_d;
        match_q <= match_d;
        start_q <= start_d;
        word_q  <= word_d;
        vcnt_q  <= vcnt_d;
      end
    end
  end

  // Result register: hold while the consumer stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_acc && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_acc && s_axis_tlast) begin
      out_status_q <= res_status;
      if (res_status == ST_FOUND) begin
        out_offset_q <= start_d;
        out_length_q <= len_d;
        out_word_q   <= word_d;
      end else begin
        out_offset_q <= '0;
        out_length_q <= '0;
        out_word_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_word_q, out_length_q, out_offset_q};

endmodule

// ===== rtl/tlvs_checker.sv =====
`timescale 1ns / 1ps
module tlvs_checker import tlvs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A new result only follows an accepted last byte.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without a last byte");

  // A pending, stalled result blocks new payload.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // Any status other than found carries zero fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == '0)
    else $error("nonzero fields without a match");

  // An empty value gives an empty value word.
  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[47:16] == 32'd0 |-> m_axis_tdata[111:48] == 64'd0)
    else $error("value bytes with zero length");

endmodule

bind tlv_record_scanner tlvs_checker u_tlvs_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Drive payload bytes into the scanner and check each per-buffer lookup result.
// A byte-level model of the scanner runs beside the block. Every accepted byte
// updates the model, and the byte marked last queues one awaited lookup.
// The result monitor pops that lookup and compares it field by field.
module tb import tlvs_pkg::*;;

  localparam int unsigned BUF_LIMIT     = 65536;
  localparam int unsigned IDLE_PCT      = 25;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_BYTES   = 220;
  localparam int unsigned PRINT_LIMIT   = 40;

  // Indexes past the two real registers; writes there must not land anywhere
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    status_e     status;
    logic [15:0] offset;
    logic [31:0] length;
    logic [63:0] word;
  } lookup_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // [7:0] data_byte
  logic                  s_axis_tlast  = 1'b0; // last_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] offset, [47:16] length, [111:48] word
  logic [1:0]            m_axis_tuser;         // [1:0] status
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Register mirror, reset values
  logic [15:0] tag_sel  = '0;
  logic [3:0]  want_len = '0;

  // Scan state mirror, reset values
  logic [2:0]  hdr_idx    = '0;
  logic [15:0] tag_acc    = '0;
  logic [31:0] len_acc    = '0;
  logic [31:0] value_owed = '0;
  logic [16:0] byte_pos   = '0;
  logic        match_seen = 1'b0;
  logic [15:0] match_off  = '0;
  logic [63:0] value_acc  = '0;

  lookup_t awaited_lookups[$];

  // Turn idling off on both sides for a stretch
  bit          steady = 1'b0;
  int unsigned error_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned buffers_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned status_count[4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;

  always #6 clk_i = ~clk_i;

  tlv_record_scanner #(
    .BUFFER_BYTES(BUF_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Advance the scan mirror by one accepted byte; queue the lookup on the last byte.
  function automatic void scan_payload_byte(input logic [7:0] b, input logic is_last);
    lookup_t     r;
    logic [31:0] k;
    // Once the matched value is complete, ignore everything up to the last byte
    if (!(match_seen && value_owed == 0)) begin
      if (value_owed != 0) begin
        // Collect only the first eight bytes of the matched value
        if (match_seen) begin
          k = len_acc - value_owed;
          if (k < 32'(WORD_BYTES)) value_acc |= 64'(b) << (8 * k);
        end
        value_owed--;
      end else begin
        if (hdr_idx == HDR_TAG_LO) begin
          tag_acc = {8'h00, b};
          len_acc = '0;
        end else if (hdr_idx == HDR_TAG_HI) begin
          tag_acc[15:8] = b;
        end else begin
          len_acc |= 32'(b) << (8 * (hdr_idx - HDR_LEN_B0));
        end
        if (hdr_idx == HDR_LEN_B3) begin
          hdr_idx    = HDR_TAG_LO;
          value_owed = len_acc;
          if (tag_acc == tag_sel) begin
            match_seen = 1'b1;
            // Offset keeps the low 16 bits, so it wraps past 64 KiB
            match_off  = byte_pos[15:0] + 16'd1;
            value_acc  = '0;
          end
        end else begin
          hdr_idx++;
        end
      end
    end
    // Position saturates at the buffer size; parsing carries on
    if (byte_pos < BUF_LIMIT) byte_pos++;

    if (is_last) begin
      r.status = ST_NOT_FOUND;
      r.offset = '0;
      r.length = '0;
      r.word   = '0;
      if (value_owed != 0) begin
        r.status = ST_MALFORMED;
      end else if (match_seen) begin
        if (want_len != 0 && len_acc != 32'(want_len)) begin
          r.status = ST_WRONG_LEN;
        end else begin
          r.status = ST_FOUND;
          r.offset = match_off;
          r.length = len_acc;
          r.word   = value_acc;
        end
      end
      awaited_lookups.push_back(r);
      // Re-arm for the next buffer
      hdr_idx    = '0;
      tag_acc    = '0;
      len_acc    = '0;
      value_owed = '0;
      byte_pos   = '0;
      match_seen = 1'b0;
      match_off  = '0;
      value_acc  = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: %s mismatch in result %0d: got 0x%0h, want 0x%0h",
               $time, what, results_seen, got, want);
    end
    error_count++;
  endtask

  // Hold each byte until accepted; drop valid only while idling.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_payload_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_buffer(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    buffers_sent++;
  endtask

  // Wait for every awaited lookup, then give the block time to go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TARGET_TAG) tag_sel = val;
    else if (idx == CFG_EXPECTED_LENGTH) want_len = val[3:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic void add_header(ref logic [7:0] q[$], input logic [15:0] tag,
                                     input logic [31:0] len);
    q.push_back(tag[7:0]);
    q.push_back(tag[15:8]);
    for (int i = 0; i < 4; i++) q.push_back(len[8*i +: 8]);
  endfunction

  function automatic void add_value(ref logic [7:0] q[$], input int unsigned n);
    for (int unsigned i = 0; i < n; i++) q.push_back(8'($urandom));
  endfunction

  // Mostly well-formed record chains with random content; the rest is noise,
  // oversized lengths, cut values and stray trailing bytes.
  function automatic void build_random_buffer(ref logic [7:0] q[$]);
    int unsigned recs;
    int unsigned len;
    logic [15:0] tag;
    q.delete();
    if ($urandom_range(9, 0) == 0) begin
      add_value(q, $urandom_range(20, 1));
      return;
    end
    recs = $urandom_range(4, 0);
    for (int unsigned r = 0; r < recs; r++) begin
      case ($urandom_range(3, 0))
        0:       tag = tag_sel;
        1:       tag = tag_sel ^ (16'h1 << $urandom_range(15, 0));
        default: tag = 16'($urandom);
      endcase
      case ($urandom_range(4, 0))
        0:       len = want_len;
        1:       len = $urandom_range(8, 0);
        2:       len = $urandom_range(40, 9);
        3:       len = $urandom_range(1, 0);
        default: len = $urandom_range(12, 0);
      endcase
      if ($urandom_range(24, 0) == 0) begin
        // Huge length: the buffer ends inside the value
        add_header(q, tag, $urandom | 32'h0000_0100);
        add_value(q, $urandom_range(6, 0));
        return;
      end
      add_header(q, tag, len);
      add_value(q, len);
    end
    case ($urandom_range(5, 0))
      0: add_value(q, $urandom_range(5, 1));     // header cut short by the end
      1: if (q.size() > 3) begin                 // value cut short, or a short header
        repeat ($urandom_range(3, 1)) q.delete(q.size() - 1);
      end
      2: add_value(q, $urandom_range(16, 6));    // stray bytes parse as more records
      default: ;
    endcase
    if (q.size() == 0) q.push_back(8'($urandom));
  endfunction

  // Reset defaults, record layouts, truncation cases and the smallest buffers.
  task automatic test_record_layouts();
    logic [7:0] q[$];
    // Reset target is tag 0
    add_header(q, 16'h0000, 32'd1);
    q.push_back(8'h5C);
    send_buffer(q);
    settle();
    write_reg(CFG_TARGET_TAG, 16'hA55A);
    // Long matching value, then a second copy of the tag that must be skipped
    q.delete();
    add_header(q, 16'h5AA5, 32'd2);
    add_value(q, 2);
    add_header(q, 16'hA55A, 32'd10);
    add_value(q, 10);
    add_header(q, 16'hA55A, 32'd1);
    add_value(q, 1);
    send_buffer(q);
    // Short trailing header after a skipped record
    q.delete();
    add_header(q, 16'h0000, 32'd0);
    add_value(q, 3);
    send_buffer(q);
    // Matching value cut by the end of the buffer
    q.delete();
    add_header(q, 16'hA55A, 32'd5);
    add_value(q, 2);
    send_buffer(q);
    // Non-matching record with the largest length
    q.delete();
    add_header(q, 16'hFFFF, 32'hFFFF_FFFF);
    q.push_back(8'hFF);
    send_buffer(q);
    // Empty matching value closing the buffer
    q.delete();
    add_header(q, 16'hA55A, 32'd0);
    send_buffer(q);
    // Empty matching value mid-buffer, trailing bytes ignored
    q.delete();
    add_header(q, 16'hA55A, 32'd0);
    add_value(q, 4);
    send_buffer(q);
    // One-byte buffers at both byte extremes
    q.delete();
    q.push_back(8'h00);
    send_buffer(q);
    q.delete();
    q.push_back(8'hFF);
    send_buffer(q);
    settle();
  endtask

  task automatic test_length_check();
    logic [7:0] q[$];
    write_reg(CFG_EXPECTED_LENGTH, 16'd4);
    add_header(q, 16'hA55A, 32'd3);
    add_value(q, 3);
    send_buffer(q);
    q.delete();
    add_header(q, 16'hA55A, 32'd4);
    add_value(q, 4);
    send_buffer(q);
    // No match at all: length check does not apply
    q.delete();
    add_header(q, 16'h0001, 32'd7);
    add_value(q, 7);
    send_buffer(q);
    settle();
    // Upper data bits drop; 15 is compared as it stands
    write_reg(CFG_EXPECTED_LENGTH, 16'hFFFF);
    q.delete();
    add_header(q, 16'hA55A, 32'd15);
    add_value(q, 15);
    send_buffer(q);
    q.delete();
    add_header(q, 16'hA55A, 32'd8);
    add_value(q, 8);
    send_buffer(q);
    settle();
    write_reg(CFG_EXPECTED_LENGTH, 16'd0);
  endtask

  task automatic test_register_index();
    logic [7:0] q[$];
    write_reg(CFG_SPARE_LO, 16'h0000);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    // Target and length must be untouched
    add_header(q, 16'hA55A, 32'd1);
    add_value(q, 1);
    send_buffer(q);
    q.delete();
    add_header(q, 16'h0000, 32'd2);
    add_value(q, 2);
    send_buffer(q);
    settle();
  endtask

  // Back-to-back buffers with no idling on either side.
  task automatic test_steady_stream();
    logic [7:0]  q[$];
    int unsigned stretch_end;
    steady = 1'b1;
    stretch_end = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stretch_end) begin
      build_random_buffer(q);
      send_buffer(q);
    end
    settle();
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [7:0]  q[$];
    logic [15:0] tags[5];
    logic [3:0]  lens[5];
    int unsigned phase_end;
    tags = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom)};
    lens = '{4'd0, 4'd8, 4'($urandom_range(7, 1)), 4'($urandom_range(15, 9)), 4'd0};
    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(CFG_TARGET_TAG, tags[p]);
      write_reg(CFG_EXPECTED_LENGTH, {12'($urandom), lens[p]});
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random_buffer(q);
        send_buffer(q);
      end
    end
  endtask

  // Result side: stall at random unless idling is off.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // Compare each accepted result with the oldest awaited lookup.
  always @(posedge clk_i) begin : check_results
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_lookups.size() == 0) begin
        report_mismatch("unrequested result, status", 64'(m_axis_tuser), '0);
      end else begin
        want = awaited_lookups.pop_front();
        status_count[want.status]++;
        if (m_axis_tuser != want.status) begin
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        end
        if (m_axis_tdata[15:0] != want.offset) begin
          report_mismatch("value_offset", 64'(m_axis_tdata[15:0]), 64'(want.offset));
        end
        if (m_axis_tdata[47:16] != want.length) begin
          report_mismatch("value_length", 64'(m_axis_tdata[47:16]), 64'(want.length));
        end
        if (m_axis_tdata[111:48] != want.word) begin
          report_mismatch("value_word", m_axis_tdata[111:48], want.word);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d lookups outstanding",
               stall_cycles, awaited_lookups.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_record_layouts();
    test_length_check();
    test_register_index();
    test_steady_stream();
    test_random_phases();

    settle();
    repeat (8) @(posedge clk_i);
    $display("Scanned %0d buffers (%0d bytes) across %0d register writes, %0d results checked.",
             buffers_sent, bytes_sent, cfg_writes, results_seen);
    $display("Statuses seen: found %0d, not found %0d, malformed %0d, wrong length %0d.",
             status_count[ST_FOUND], status_count[ST_NOT_FOUND],
             status_count[ST_MALFORMED], status_count[ST_WRONG_LEN]);
    if (error_count == 0 && awaited_lookups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
